// ===== rtl/core/dbt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbt_pkg: shared types and codes for the device binding table
// Operation, status and mode codes plus the controller/datapath command bus.
// ----------------------------------------------------------------------------
package dbt_pkg;

    typedef enum logic [2:0] {
        OP_OBSERVE = 3'd0, OP_BIND = 3'd1, OP_UNBIND = 3'd2, OP_CONNECTED = 3'd3,
        OP_DISCONN = 3'd4, OP_FAILED = 3'd5, OP_SCAN = 3'd6, OP_QUERY = 3'd7
    } t_op;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_LIMIT     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [2:0] M_DISCOVERED   = 3'd0;
    localparam logic [2:0] M_CONNECTING   = 3'd1;
    localparam logic [2:0] M_BOUND        = 3'd2;
    localparam logic [2:0] M_RECONNECTING = 3'd3;
    localparam logic [2:0] M_ERROR        = 3'd4;

    localparam logic [1:0] CFG_BOUND_LIMIT = 2'd0;
    localparam logic [1:0] CFG_BASE        = 2'd1;
    localparam logic [1:0] CFG_CAP         = 2'd2;
    localparam logic [1:0] CFG_SHIFT       = 2'd3;

    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input beat, start scan at slot 0
        logic step;     // evaluate current slot, advance index
        logic apply;    // perform the operation's update
        logic emit_key; // due-scan key result consumed, mark slot connecting
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;  // index reached used count
        logic due_hit;    // current slot is due (scan mode)
        logic cap_full;   // due count reached capacity
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/core/dbt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbt_ctrl: sequencer for the device binding table
// Walks the slots one per cycle, pausing in scan mode while each due key waits to
// be taken, then applies the update and issues the final result.
module dbt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic           i_is_scan,
    input  wire dbt_pkg::t_sts  i_sts,
    output dbt_pkg::t_cmd       o_cmd,
    output logic                o_out_valid,
    output logic                o_out_last,
    input  wire logic           i_out_ready
);
    import dbt_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_WALK, S_APPLY, S_KEY, S_RESULT} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_out_last, n_out_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;

    // command decode
    always_comb begin
        o_cmd = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step     = (r_state == S_WALK) && !i_sts.scan_done &&
                         !(i_is_scan && (i_sts.due_hit || i_sts.cap_full));
        o_cmd.apply    = (r_state == S_APPLY);
        o_cmd.emit_key = (r_state == S_KEY) && i_out_ready;
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_WALK;
            end
            S_WALK: begin
                if (i_is_scan && i_sts.due_hit && !i_sts.cap_full) begin
                    n_state     = S_KEY;
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b0;
                end else if (i_sts.scan_done || (i_is_scan && i_sts.cap_full)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state     = S_RESULT;
                n_out_valid = 1'b1;
                n_out_last  = 1'b1;
            end
            S_KEY: begin
                if (i_out_ready) begin
                    n_state     = S_WALK;
                    n_out_valid = 1'b0;
                end
            end
            S_RESULT: begin
                if (i_out_ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/dbt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbt_datapath: slot storage, walk index and backoff arithmetic
// One slot is examined per walk cycle while no due key is held in scan mode:
// key match, eviction candidate, wanted count and due test.
// ----------------------------------------------------------------------------
module dbt_datapath #(
    parameter int TABLE_SLOTS = 16,
    parameter int KEY_BITS    = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_idx,
    input  wire logic [22:0]     i_cfg_data,
    input  wire logic [2:0]      i_op,
    input  wire logic [KEY_BITS-1:0] i_device_key,
    input  wire logic [47:0]     i_now_ms,
    input  wire logic [4:0]      i_capacity,
    input  wire dbt_pkg::t_cmd   i_cmd,
    output dbt_pkg::t_sts        o_sts,
    output logic                 o_is_scan,
    output logic [2:0]           o_status,
    output logic [2:0]           o_entry_state,
    output logic                 o_entry_wanted,
    output logic [KEY_BITS-1:0]  o_due_key,
    output logic [4:0]           o_due_count
);
    import dbt_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    // configuration
    logic [4:0]  r_bound_limit;
    logic [15:0] r_base;
    logic [22:0] r_cap;
    logic [3:0]  r_max_shift;

    // table state
    logic [CW-1:0]       r_used;
    logic [63:0]         r_seq;
    logic [KEY_BITS-1:0] r_key     [TABLE_SLOTS];
    logic [63:0]         r_seen    [TABLE_SLOTS];
    logic                r_wanted  [TABLE_SLOTS];
    logic [2:0]          r_mode    [TABLE_SLOTS];
    logic [7:0]          r_att     [TABLE_SLOTS];
    logic [47:0]         r_retry   [TABLE_SLOTS];
    logic                r_pend    [TABLE_SLOTS];

    // captured beat and walk results
    logic [2:0]          r_op;
    logic [KEY_BITS-1:0] r_dkey;
    logic [47:0]         r_now;
    logic [CW-1:0]       r_capn;
    logic [CW-1:0]       r_idx;
    logic                r_hit;
    logic [IW-1:0]       r_hit_idx;
    logic                r_ev_ok;
    logic [IW-1:0]       r_ev_idx;
    logic [CW-1:0]       r_nwant;
    logic [CW-1:0]       r_count;

    logic [IW-1:0] cur;
    logic          key_zero;
    logic          due_now;
    logic [IW-1:0] sel;

    assign cur      = r_idx[IW-1:0];
    assign key_zero = (r_dkey == '0);
    assign due_now  = r_wanted[cur] && r_pend[cur] && (r_retry[cur] <= r_now);

    assign o_is_scan       = (r_op == OP_SCAN);
    assign o_sts.scan_done = (r_idx >= r_used);
    assign o_sts.due_hit   = !o_sts.scan_done && due_now;
    assign o_sts.cap_full  = (r_count >= r_capn);

    // backoff delay for the attempt count after increment
    logic [7:0]  att_inc;
    logic [7:0]  att_m1;
    logic [3:0]  shamt;
    logic [30:0] shifted;
    logic [22:0] delay;
    logic [48:0] tsum;
    logic [47:0] tnext;

    assign sel     = r_hit_idx;
    assign att_inc = (r_att[sel] == 8'hFF) ? 8'hFF : r_att[sel] + 8'd1;
    assign att_m1  = att_inc - 8'd1;
    assign shamt   = (att_m1 > {4'd0, r_max_shift}) ? r_max_shift : att_m1[3:0];
    assign shifted = {15'd0, r_base} << shamt;
    assign delay   = (shifted > {8'd0, r_cap}) ? r_cap : shifted[22:0];
    assign tsum    = {1'b0, r_now} + {26'd0, delay};
    assign tnext   = tsum[48] ? TIME_MAX : tsum[47:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_limit <= 5'd4;
            r_base        <= 16'd500;
            r_cap         <= 23'd30000;
            r_max_shift   <= 4'd6;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOUND_LIMIT: r_bound_limit <= i_cfg_data[4:0];
                CFG_BASE:        r_base        <= i_cfg_data[15:0];
                CFG_CAP:         r_cap         <= i_cfg_data;
                CFG_SHIFT:       r_max_shift   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // control state: counters, walk, outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_seq  <= '0;
            r_op   <= OP_QUERY;
            r_idx  <= '0;
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_op    <= i_op;
            r_dkey  <= i_device_key;
            r_now   <= i_now_ms;
            r_capn  <= (i_capacity > 5'(TABLE_SLOTS)) ? CW'(TABLE_SLOTS)
                                                       : CW'(i_capacity);
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_ev_ok <= 1'b0;
            r_nwant <= '0;
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
            if (!key_zero && !r_hit && r_key[cur] == r_dkey) begin
                r_hit     <= 1'b1;
                r_hit_idx <= cur;
            end
            if (!r_wanted[cur] &&
                (!r_ev_ok || r_seen[cur] < r_seen[r_ev_idx])) begin
                r_ev_ok  <= 1'b1;
                r_ev_idx <= cur;
            end
            if (r_wanted[cur]) r_nwant <= r_nwant + 1'b1;
        end else if (i_cmd.emit_key) begin
            r_idx   <= r_idx + 1'b1;
            r_count <= r_count + 1'b1;
        end else if (i_cmd.apply) begin
            o_status       <= ST_OK;
            o_entry_state  <= M_DISCOVERED;
            o_entry_wanted <= 1'b0;
            o_due_key      <= '0;
            o_due_count    <= 5'(r_count);
            if (r_op == OP_OBSERVE) begin
                if (key_zero) begin
                    o_status <= ST_INVALID;
                end else begin
                    r_seq <= r_seq + 64'd1;
                    o_entry_state  <= r_hit ? r_mode[r_hit_idx] : M_DISCOVERED;
                    o_entry_wanted <= r_hit ? r_wanted[r_hit_idx] : 1'b0;
                    if (!r_hit && r_used < CW'(TABLE_SLOTS)) r_used <= r_used + 1'b1;
                    if (!r_hit && r_used >= CW'(TABLE_SLOTS) && !r_ev_ok) begin
                        o_status <= ST_FULL;
                        r_seq    <= r_seq;
                    end
                end
            end else if (r_op != OP_SCAN) begin
                if (!r_hit) begin
                    o_status <= ST_NOT_FOUND;
                end else begin
                    o_entry_state  <= r_mode[sel];
                    o_entry_wanted <= r_wanted[sel];
                    unique case (r_op)
                        OP_BIND: begin
                            if (!r_wanted[sel] && {{(8-CW){1'b0}}, r_nwant} >=
                                {3'd0, r_bound_limit}) begin
                                o_status <= ST_LIMIT;
                            end else if (!(r_wanted[sel] && (r_mode[sel] == M_CONNECTING
                                       || r_mode[sel] == M_BOUND))) begin
                                o_entry_state  <= M_CONNECTING;
                                o_entry_wanted <= 1'b1;
                            end
                        end
                        OP_UNBIND: begin
                            o_entry_state  <= M_DISCOVERED;
                            o_entry_wanted <= 1'b0;
                        end
                        OP_CONNECTED: begin
                            if (!r_wanted[sel]) o_status <= ST_INVALID;
                            else o_entry_state <= M_BOUND;
                        end
                        OP_DISCONN, OP_FAILED: begin
                            if (!r_wanted[sel]) o_entry_state <= M_DISCOVERED;
                            else o_entry_state <= (r_op == OP_DISCONN) ? M_RECONNECTING
                                                                         : M_ERROR;
                        end
                        default: ;
                    endcase
                end
            end
        end else if (o_is_scan && o_sts.due_hit && !o_sts.cap_full) begin
            // present the due key while the controller raises valid
            o_status       <= ST_OK;
            o_entry_state  <= M_CONNECTING;
            o_entry_wanted <= 1'b1;
            o_due_key      <= r_key[cur];
            o_due_count    <= '0;
        end
    end

    // slot array updates
    logic [IW-1:0] new_slot;
    assign new_slot = (r_used < CW'(TABLE_SLOTS)) ? r_used[IW-1:0] : r_ev_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_key) begin
            r_mode[cur]  <= M_CONNECTING;
            r_pend[cur]  <= 1'b0;
            r_retry[cur] <= '0;
        end else if (i_cmd.apply && r_op == OP_OBSERVE && !key_zero) begin
            if (r_hit) begin
                r_seen[r_hit_idx] <= r_seq + 64'd1;
            end else if (r_used < CW'(TABLE_SLOTS) || r_ev_ok) begin
                r_key[new_slot]    <= r_dkey;
                r_wanted[new_slot] <= 1'b0;
                r_mode[new_slot]   <= M_DISCOVERED;
                r_att[new_slot]    <= '0;
                r_retry[new_slot]  <= '0;
                r_pend[new_slot]   <= 1'b0;
                r_seen[new_slot]   <= r_seq + 64'd1;
            end
        end else if (i_cmd.apply && r_hit && r_op != OP_SCAN) begin
            unique case (r_op)
                OP_BIND: begin
                    if (!(!r_wanted[sel] && {{(8-CW){1'b0}}, r_nwant} >=
                          {3'd0, r_bound_limit}) &&
                        !(r_wanted[sel] && (r_mode[sel] == M_CONNECTING ||
                                            r_mode[sel] == M_BOUND))) begin
                        r_wanted[sel] <= 1'b1;
                        r_mode[sel]   <= M_CONNECTING;
                        r_retry[sel]  <= '0;
                        r_pend[sel]   <= 1'b0;
                    end
                end
                OP_UNBIND: begin
                    r_wanted[sel] <= 1'b0;
                    r_mode[sel]   <= M_DISCOVERED;
                    r_att[sel]    <= '0;
                    r_retry[sel]  <= '0;
                    r_pend[sel]   <= 1'b0;
                end
                OP_CONNECTED: begin
                    if (r_wanted[sel]) begin
                        r_mode[sel]  <= M_BOUND;
                        r_att[sel]   <= '0;
                        r_retry[sel] <= '0;
                        r_pend[sel]  <= 1'b0;
                    end
                end
                OP_DISCONN, OP_FAILED: begin
                    if (!r_wanted[sel]) begin
                        r_mode[sel] <= M_DISCOVERED;
                    end else begin
                        r_att[sel]   <= att_inc;
                        r_mode[sel]  <= (r_op == OP_DISCONN) ? M_RECONNECTING : M_ERROR;
                        r_retry[sel] <= tnext;
                        r_pend[sel]  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/device_binding_table_backoff_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// device_binding_table_backoff_core: device table with reconnect backoff
//
//  channel | direction | handshake        | beat
//  in      | input     | i_in_valid/ready | op, key, time, capacity
//  out     | output    | o_out_valid/ready| status, state, wanted, key, count
//  cfg     | input     | i_cfg_we         | index, data (no wait)
//
// An item walks the slot array, one slot a cycle unless a due key waits to be
// taken, then applies its update and returns the result beat.
// Reset is synchronous and active low; it empties the table.
// One item is in flight at a time; input is taken only when idle.
// ----------------------------------------------------------------------------
module device_binding_table_backoff_core #(
    parameter int TABLE_SLOTS = 16,
    parameter int KEY_BITS    = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [22:0]         i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [2:0]          i_op,
    input  wire logic [KEY_BITS-1:0] i_device_key,
    input  wire logic [47:0]         i_now_ms,
    input  wire logic [4:0]          i_capacity,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [2:0]               o_status,
    output logic [2:0]               o_entry_state,
    output logic                     o_entry_wanted,
    output logic [KEY_BITS-1:0]      o_due_key,
    output logic [4:0]               o_due_count,
    output logic                     o_last
);
    import dbt_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic is_scan;

    dbt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready,
        .i_is_scan(is_scan), .i_sts(sts), .o_cmd(cmd),
        .o_out_valid, .o_out_last(o_last), .i_out_ready
    );

    dbt_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_op, .i_device_key, .i_now_ms, .i_capacity,
        .i_cmd(cmd), .o_sts(sts), .o_is_scan(is_scan),
        .o_status, .o_entry_state, .o_entry_wanted, .o_due_key, .o_due_count
    );
endmodule
`default_nettype wire

// ===== rtl/core/dbt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbt_checker: port-level checks for the device binding table
// Watches the handshakes and result framing.
// ----------------------------------------------------------------------------
module dbt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_last,
    input wire logic [2:0] o_status,
    input wire logic [4:0] o_due_count
);
    // output beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_last))
        else $error("output beat dropped");

    // no new input while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken during result");

    // accepted input gives no result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_out_valid)
        else $error("result too early");

    // key beats carry ok status and no count
    a_key_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_status == 3'd0 && o_due_count == 5'd0)
        else $error("bad key beat");
endmodule

bind device_binding_table_backoff_core dbt_checker u_chk (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
    .o_last, .o_status, .o_due_count
);
`default_nettype wire

// ===== tb/device_binding_table_backoff_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_binding_table_backoff_core_tb: self-checking bench for the device table
// Directed and random operations with random gaps on both channels. A local
// table model predicts every result beat, and the monitor checks each beat.
// ----------------------------------------------------------------------------
module device_binding_table_backoff_core_tb;
    import dbt_pkg::*;

    localparam int SLOTS = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] key;
        logic [47:0] now;
        logic [4:0]  cap;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  mode;
        logic        wanted;
        logic [63:0] key;
        logic [4:0]  count;
        logic        last;
    } t_beat;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [22:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  op;
    logic [63:0] dkey;
    logic [47:0] now_ms;
    logic [4:0]  cap;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  o_status;
    logic [2:0]  o_mode;
    logic        o_wanted;
    logic [63:0] o_key;
    logic [4:0]  o_count;
    logic        o_last;

    device_binding_table_backoff_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_op(op), .i_device_key(dkey), .i_now_ms(now_ms), .i_capacity(cap),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_status(o_status), .o_entry_state(o_mode), .o_entry_wanted(o_wanted),
        .o_due_key(o_key), .o_due_count(o_count), .o_last(o_last)
    );

    // table model state
    logic [4:0]  lim_r;
    logic [15:0] base_r;
    logic [22:0] capms_r;
    logic [3:0]  shift_r;
    int          used_n;
    logic [63:0] seq_n;
    logic [63:0] tkey   [SLOTS];
    logic [63:0] tseen  [SLOTS];
    logic        twant  [SLOTS];
    logic [2:0]  tmode  [SLOTS];
    logic [7:0]  tatt   [SLOTS];
    logic [47:0] tretry [SLOTS];
    logic        tpend  [SLOTS];

    t_item pending_q[$];
    t_beat expected_q[$];
    int    errors;
    int    accepted;
    int    cycles;
    bit    hold_req;
    int    hold_cnt;
    logic  hold_off;
    int    in_gap;
    int    out_gap;
    logic [63:0] keypool[8];

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int find_slot(logic [63:0] k);
        if (k == 0) return -1;
        for (int i = 0; i < used_n; i++) if (tkey[i] == k) return i;
        return -1;
    endfunction

    function automatic logic [47:0] backoff_delay(logic [7:0] att);
        logic [63:0] sh;
        logic [63:0] d;
        sh = (att > 0) ? att - 1 : 0;
        if (sh > shift_r) sh = shift_r;
        d = 64'(base_r) << sh[3:0];
        return (d > capms_r) ? 48'(capms_r) : 48'(d);
    endfunction

    function automatic t_beat mk(logic [2:0] st, logic [2:0] m, logic w,
                                 logic [63:0] k, logic [4:0] c, logic l);
        t_beat b;
        b.status = st; b.mode = m; b.wanted = w; b.key = k; b.count = c; b.last = l;
        return b;
    endfunction

    // work out the beats caused by one accepted item
    task automatic predict_table(t_item it);
        int s;
        int nw;
        int cnt;
        int lim;
        logic [2:0] st;
        logic [48:0] t;
        s = -1; st = ST_OK;
        if (it.op == OP_SCAN) begin
            cnt = 0;
            lim = (it.cap > SLOTS) ? SLOTS : it.cap;
            for (int i = 0; i < used_n && cnt < lim; i++) begin
                if (!twant[i] || !tpend[i] || tretry[i] > it.now) continue;
                tmode[i] = M_CONNECTING; tpend[i] = 0; tretry[i] = 0;
                expected_q.push_back(mk(ST_OK, M_CONNECTING, 1, tkey[i], 0, 0));
                cnt++;
            end
            expected_q.push_back(mk(ST_OK, M_DISCOVERED, 0, 0, 5'(cnt), 1));
            return;
        end
        if (it.op == OP_OBSERVE) begin
            if (it.key == 0) st = ST_INVALID;
            else begin
                s = find_slot(it.key);
                if (s >= 0) begin
                    seq_n++; tseen[s] = seq_n;
                end else begin
                    if (used_n < SLOTS) begin
                        s = used_n; used_n++;
                    end else begin
                        for (int i = 0; i < SLOTS; i++)
                            if (!twant[i] && (s < 0 || tseen[i] < tseen[s])) s = i;
                    end
                    if (s < 0) st = ST_FULL;
                    else begin
                        tkey[s] = it.key; twant[s] = 0; tmode[s] = M_DISCOVERED;
                        tatt[s] = 0; tretry[s] = 0; tpend[s] = 0;
                        seq_n++; tseen[s] = seq_n;
                    end
                end
            end
        end else begin
            s = find_slot(it.key);
            if (s < 0) st = ST_NOT_FOUND;
            else case (it.op)
                OP_BIND: begin
                    nw = 0;
                    for (int i = 0; i < used_n; i++) if (twant[i]) nw++;
                    if (!twant[s] && nw >= lim_r) st = ST_LIMIT;
                    else if (!(twant[s] && (tmode[s] == M_CONNECTING ||
                                            tmode[s] == M_BOUND))) begin
                        twant[s] = 1; tmode[s] = M_CONNECTING; tretry[s] = 0; tpend[s] = 0;
                    end
                end
                OP_UNBIND: begin
                    twant[s] = 0; tmode[s] = M_DISCOVERED; tatt[s] = 0;
                    tretry[s] = 0; tpend[s] = 0;
                end
                OP_CONNECTED: begin
                    if (!twant[s]) st = ST_INVALID;
                    else begin
                        tmode[s] = M_BOUND; tatt[s] = 0; tretry[s] = 0; tpend[s] = 0;
                    end
                end
                OP_DISCONN, OP_FAILED: begin
                    if (!twant[s]) tmode[s] = M_DISCOVERED;
                    else begin
                        if (tatt[s] < 255) tatt[s]++;
                        tmode[s] = (it.op == OP_DISCONN) ? M_RECONNECTING : M_ERROR;
                        t = 49'(it.now) + 49'(backoff_delay(tatt[s]));
                        tretry[s] = (t > TIME_MAX) ? TIME_MAX : t[47:0];
                        tpend[s] = 1;
                    end
                end
                default: ;
            endcase
        end
        if (s >= 0) expected_q.push_back(mk(st, tmode[s], twant[s], 0, 0, 1));
        else expected_q.push_back(mk(st, M_DISCOVERED, 0, 0, 0, 1));
    endtask

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    endfunction

    // driver: predicts on acceptance, offers queued items
    logic in_acc;
    always @(posedge clk) begin
        in_acc <= 1'b0;
        if (rst_n && in_valid && in_ready) begin
            predict_table('{op, dkey, now_ms, cap});
            accepted <= accepted + 1;
            in_acc <= 1'b1;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_acc) begin
            // hold payload until accepted
        end else if (in_gap > 0) begin
            in_gap <= in_gap - 1;
            in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
            t_item it;
            it = pending_q.pop_front();
            op <= it.op; dkey <= it.key; now_ms <= it.now; cap <= it.cap;
            in_valid <= 1'b1;
            in_gap <= pick_gap();
        end else begin
            in_valid <= 1'b0;
        end
    end

    // monitor: checks each result beat against the oldest expectation
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready) begin
            t_beat got;
            t_beat exp_b;
            got = mk(o_status, o_mode, o_wanted, o_key, o_count, o_last);
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %p", got);
            end else begin
                exp_b = expected_q.pop_front();
                if (got !== exp_b) begin
                    errors++;
                    if (errors <= 10) $display("mismatch exp %p got %p", exp_b, got);
                end
            end
        end
    end

    // long receiver hold-off, counted here once requested
    assign hold_off = hold_req && (hold_cnt < HOLD_CYCLES);
    always @(posedge clk) begin
        if (!hold_req) hold_cnt <= 0;
        else if (hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
    end

    // receiver stalls, with one long hold-off on request
    always @(negedge clk) begin
        if (!rst_n) out_ready <= 1'b0;
        else if (hold_off) out_ready <= 1'b0;
        else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
        end
    end

    always @(posedge clk) begin
        if (cycles > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [22:0] val);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BOUND_LIMIT: lim_r = val[4:0];
            CFG_BASE:        base_r = val[15:0];
            CFG_CAP:         capms_r = val;
            default:         shift_r = val[3:0];
        endcase
    endtask

    task automatic wait_idle();
        while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic t_item rnd_item(int nkeys);
        t_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) it.op = OP_OBSERVE;
        else if (r < 45) it.op = OP_BIND;
        else if (r < 50) it.op = OP_UNBIND;
        else if (r < 58) it.op = OP_CONNECTED;
        else if (r < 68) it.op = OP_DISCONN;
        else if (r < 76) it.op = OP_FAILED;
        else if (r < 90) it.op = OP_SCAN;
        else it.op = OP_QUERY;
        r = $urandom_range(0, 19);
        if (r == 0) it.key = 0;
        else if (r == 1) it.key = {$urandom, $urandom};
        else it.key = keypool[$urandom_range(0, nkeys - 1)];
        it.now = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom}) :
                 48'(1000 * $urandom_range(0, 200));
        it.cap = 5'($urandom_range(0, 31));
        return it;
    endfunction

    function automatic t_item it_of(logic [2:0] o, logic [63:0] k, logic [47:0] t,
                                    logic [4:0] c);
        t_item it;
        it.op = o; it.key = k; it.now = t; it.cap = c;
        return it;
    endfunction

    initial begin
        rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        in_valid = 1'b0; out_ready = 1'b0; op = '0; dkey = '0; now_ms = '0; cap = '0;
        in_gap = 0; out_gap = 0; hold_req = 1'b0; errors = 0; accepted = 0; cycles = 0;
        in_acc = 1'b0;
        lim_r = 4; base_r = 500; capms_r = 30000; shift_r = 6;
        used_n = 0; seq_n = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tkey[i] = 0; tseen[i] = 0; twant[i] = 0; tmode[i] = 0;
            tatt[i] = 0; tretry[i] = 0; tpend[i] = 0;
        end
        keypool = '{64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                    64'h5555_AAAA_1234_5678, 64'hAAAA_5555_EDCB_A987, 64'h42,
                    64'h7FFF_FFFF_FFFF_FFFF, 64'hDEAD};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty key, unknown key, lifecycle, saturation, scan extremes
        pending_q.push_back(it_of(OP_OBSERVE, 0, 0, 0));
        pending_q.push_back(it_of(OP_BIND, 0, 0, 0));
        pending_q.push_back(it_of(OP_QUERY, 64'h99, 0, 0));
        pending_q.push_back(it_of(OP_OBSERVE, keypool[0], 0, 0));
        pending_q.push_back(it_of(OP_OBSERVE, keypool[1], 0, 0));
        pending_q.push_back(it_of(OP_CONNECTED, keypool[0], 0, 0));
        pending_q.push_back(it_of(OP_DISCONN, keypool[0], 5, 0));
        pending_q.push_back(it_of(OP_BIND, keypool[0], 0, 0));
        pending_q.push_back(it_of(OP_BIND, keypool[0], 0, 0));
        pending_q.push_back(it_of(OP_CONNECTED, keypool[0], 0, 0));
        pending_q.push_back(it_of(OP_BIND, keypool[1], 0, 0));
        pending_q.push_back(it_of(OP_FAILED, keypool[1], 100, 0));
        pending_q.push_back(it_of(OP_DISCONN, keypool[0], TIME_MAX - 3, 0));
        pending_q.push_back(it_of(OP_SCAN, 0, 599, 31));
        pending_q.push_back(it_of(OP_SCAN, 0, TIME_MAX, 0));
        pending_q.push_back(it_of(OP_SCAN, 0, TIME_MAX, 16));
        pending_q.push_back(it_of(OP_UNBIND, keypool[1], 0, 0));
        pending_q.push_back(it_of(OP_QUERY, keypool[1], 0, 0));
        pending_q.push_back(it_of(OP_OBSERVE, keypool[1], 0, 0));
        wait_idle();

        // max base and shift, large cap, bound limit 1, then attempts to reach saturation
        cfg_write(CFG_BOUND_LIMIT, 23'd1);
        cfg_write(CFG_BASE, 23'd65535);
        cfg_write(CFG_CAP, 23'd4194304);
        cfg_write(CFG_SHIFT, 23'd15);
        for (int i = 0; i < 20; i++) begin
            pending_q.push_back(rnd_item(4));
            pending_q.push_back(it_of(OP_FAILED, keypool[0], 48'(i), 0));
        end
        wait_idle();

        // fill past capacity with many keys to force eviction and table full
        cfg_write(CFG_BOUND_LIMIT, 23'd16);
        cfg_write(CFG_BASE, 23'd1);
        cfg_write(CFG_CAP, 23'd1);
        cfg_write(CFG_SHIFT, 23'd0);
        for (int i = 0; i < 20; i++) begin
            pending_q.push_back(it_of(OP_OBSERVE, 64'h100 + i, 0, 0));
            pending_q.push_back(it_of(OP_BIND, 64'h100 + i, 0, 0));
        end
        pending_q.push_back(it_of(OP_OBSERVE, 64'h999, 0, 0));
        // long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        wait (hold_cnt >= HOLD_CYCLES);
        hold_req = 1'b0;
        wait_idle();

        cfg_write(CFG_BOUND_LIMIT, 23'd4);
        cfg_write(CFG_BASE, 23'd500);
        cfg_write(CFG_CAP, 23'd30000);
        cfg_write(CFG_SHIFT, 23'd6);
        for (int i = 0; i < 16; i++) pending_q.push_back(it_of(OP_UNBIND, 64'h100 + i, 0, 0));
        for (int i = 0; i < 14; i++) pending_q.push_back(rnd_item(8));
        wait_idle();

        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== device_binding_table_backoff_core.f =====
rtl/core/dbt_pkg.sv
rtl/core/dbt_ctrl.sv
rtl/core/dbt_datapath.sv
rtl/core/device_binding_table_backoff_core.sv
rtl/core/dbt_checker.sv
tb/device_binding_table_backoff_core_tb.sv
